FILE: rtl/uafc_pkg.sv
// ----------------------------------------------------------------------------
// uafc_pkg
// Shared types and constants of the username/password frame checker.
// ----------------------------------------------------------------------------
package uafc_pkg;

  localparam int POS_W = 8;
  localparam int COUNT_W = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W = 3;

  localparam logic [1:0] ACT_STREAM = 2'd0;
  localparam logic [1:0] ACT_CHAR = 2'd1;
  localparam logic [1:0] ACT_LEN = 2'd2;

  localparam logic [7:0] AUTH_V1 = 8'd1;
  localparam logic STATUS_SUCCESS = 1'b0;
  localparam logic STATUS_FAILURE = 1'b1;

  typedef struct packed {
    logic start;
    logic clr_ended;
    logic cmp_a;
    logic a_zero;
    logic fin;
    logic done;
  } uafc_cmd_t;

endpackage

FILE: rtl/uafc_ram.sv
// ----------------------------------------------------------------------------
// uafc_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module uafc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 255
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  output logic [WIDTH-1:0]                       rdata_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                       rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: rtl/uafc_front.sv
// ----------------------------------------------------------------------------
// uafc_front
// Request parser, identity table and per-entry byte comparison stage.
// ----------------------------------------------------------------------------
module uafc_front
  import uafc_pkg::*;
#(
  parameter int MAX_IDENTITIES = 8,
  parameter int MAX_STRING_BYTES = 255
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [1:0]                action,
  input  logic [7:0]                data_byte,
  input  logic [2:0]                entry_index,
  input  logic                      which_string,
  input  logic [POS_W-1:0]          char_position,
  output logic                      push,
  output uafc_cmd_t                 cmd,
  output logic [MAX_IDENTITIES-1:0] eq,
  output logic [MAX_IDENTITIES-1:0] fin_ok
);

  localparam int AW = (MAX_STRING_BYTES > 1) ? $clog2(MAX_STRING_BYTES) : 1;
  localparam logic [POS_W:0] MAX_POS = (POS_W + 1)'(MAX_STRING_BYTES);

  localparam logic [2:0] PH_VERSION = 3'd0;
  localparam logic [2:0] PH_NAME_LEN = 3'd1;
  localparam logic [2:0] PH_NAME = 3'd2;
  localparam logic [2:0] PH_PASS_LEN = 3'd3;
  localparam logic [2:0] PH_PASS = 3'd4;

  logic [2:0]       phase, phase_next;
  logic [POS_W-1:0] fpos, fpos_next;
  logic [POS_W-1:0] flen, flen_next;
  logic [POS_W-1:0] fpos_inc;
  logic             stream_acc;
  logic             w;
  logic             fin_b;
  uafc_cmd_t        cmd_next;

  logic             s1_valid;
  uafc_cmd_t        s1_cmd;
  logic             s1_w;
  logic             s1_fin_b;
  logic [7:0]       s1_byte;
  logic [POS_W-1:0] s1_pos_a;
  logic [POS_W-1:0] s1_pos_b;

  assign stream_acc = accept && (action == ACT_STREAM);
  assign fpos_inc = fpos + POS_W'(1);

  always_comb begin
    phase_next = phase;
    fpos_next = fpos;
    flen_next = flen;
    cmd_next = '0;
    w = 1'b0;
    fin_b = 1'b0;
    unique case (phase)
      PH_NAME_LEN, PH_PASS_LEN: begin
        w = (phase == PH_PASS_LEN);
        flen_next = data_byte;
        fpos_next = '0;
        cmd_next.clr_ended = 1'b1;
        if (data_byte == 8'd0) begin
          cmd_next.fin = 1'b1;
          if (w) begin
            cmd_next.done = 1'b1;
            phase_next = PH_VERSION;
          end else begin
            phase_next = PH_PASS_LEN;
          end
        end else begin
          phase_next = w ? PH_PASS : PH_NAME;
        end
      end
      PH_NAME, PH_PASS: begin
        w = (phase == PH_PASS);
        cmd_next.cmp_a = 1'b1;
        cmd_next.a_zero = (data_byte == 8'd0);
        if (fpos_inc >= flen) begin
          cmd_next.fin = 1'b1;
          fin_b = 1'b1;
          fpos_next = '0;
          if (w) begin
            cmd_next.done = 1'b1;
            phase_next = PH_VERSION;
          end else begin
            phase_next = PH_PASS_LEN;
          end
        end else begin
          fpos_next = fpos_inc;
        end
      end
      default: begin
        cmd_next.start = 1'b1;
        cmd_next.clr_ended = 1'b1;
        fpos_next = '0;
        flen_next = '0;
        phase_next = PH_NAME_LEN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_VERSION;
      fpos <= '0;
      flen <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= stream_acc;
      if (stream_acc) begin
        phase <= phase_next;
        fpos <= fpos_next;
        flen <= flen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stream_acc) begin
      s1_cmd <= cmd_next;
      s1_w <= w;
      s1_fin_b <= fin_b;
      s1_byte <= data_byte;
      s1_pos_a <= fpos;
      s1_pos_b <= fpos_inc;
    end
  end

  for (genvar e = 0; e < MAX_IDENTITIES; e++) begin : g_entry
    logic       hit;
    logic       char_we;
    logic [7:0] name_len;
    logic [7:0] pass_len;
    logic [7:0] name_a;
    logic [7:0] name_b;
    logic [7:0] sec_a;
    logic [7:0] sec_b;
    logic [7:0] len;
    logic [7:0] ch_a;
    logic [7:0] ch_b;
    logic [7:0] ch_fin;

    assign hit = (32'(entry_index) == e);
    assign char_we = accept && (action == ACT_CHAR) && hit &&
                     ({1'b0, char_position} < MAX_POS);

    always_ff @(posedge clk) begin
      if (accept && (action == ACT_LEN) && hit) begin
        if (which_string) begin
          pass_len <= data_byte;
        end else begin
          name_len <= data_byte;
        end
      end
    end

    uafc_ram #(
      .WIDTH(8),
      .DEPTH(MAX_STRING_BYTES)
    ) u_name_ram (
      .clk(clk),
      .we(char_we && !which_string),
      .waddr(char_position[AW-1:0]),
      .wdata(data_byte),
      .raddr_a(fpos[AW-1:0]),
      .rdata_a(name_a),
      .raddr_b(fpos_inc[AW-1:0]),
      .rdata_b(name_b)
    );

    uafc_ram #(
      .WIDTH(8),
      .DEPTH(MAX_STRING_BYTES)
    ) u_secret_ram (
      .clk(clk),
      .we(char_we && which_string),
      .waddr(char_position[AW-1:0]),
      .wdata(data_byte),
      .raddr_a(fpos[AW-1:0]),
      .rdata_a(sec_a),
      .raddr_b(fpos_inc[AW-1:0]),
      .rdata_b(sec_b)
    );

    assign len = s1_w ? pass_len : name_len;
    assign ch_a = ((s1_pos_a < len) && ({1'b0, s1_pos_a} < MAX_POS)) ?
                  (s1_w ? sec_a : name_a) : 8'd0;
    assign ch_b = ((s1_pos_b < len) && ({1'b0, s1_pos_b} < MAX_POS)) ?
                  (s1_w ? sec_b : name_b) : 8'd0;
    assign ch_fin = s1_fin_b ? ch_b : ch_a;
    assign eq[e] = (ch_a == s1_byte);
    assign fin_ok[e] = (ch_fin == 8'd0);
  end

  assign push = s1_valid;
  assign cmd = s1_cmd;

  a_done_returns: assert property (@(posedge clk) disable iff (rst)
    (stream_acc && cmd_next.done) |=> (phase == PH_VERSION))
    else $error("phase did not return to the version byte after a reply");

  a_done_has_fin: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_cmd.done) |-> s1_cmd.fin)
    else $error("reply requested without a closing field check");

endmodule

FILE: rtl/uafc_queue.sv
// ----------------------------------------------------------------------------
// uafc_queue
// Short first-in first-out queue between the compare stage and the matcher.
// ----------------------------------------------------------------------------
module uafc_queue
  import uafc_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              pop,
  output logic [WIDTH-1:0]  rdata,
  output logic              empty,
  output logic [QCNT_W-1:0] count
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  assign rdata = mem[rd_ptr];
  assign empty = (count == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> ((count < QCNT_W'(QUEUE_DEPTH)) || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("queue read while empty");

endmodule

FILE: rtl/uafc_back.sv
// ----------------------------------------------------------------------------
// uafc_back
// Match vector update, identity count register and reply output register.
// ----------------------------------------------------------------------------
module uafc_back
  import uafc_pkg::*;
#(
  parameter int MAX_IDENTITIES = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [COUNT_W-1:0]        cfg_data,
  input  logic                      q_empty,
  input  uafc_cmd_t                 q_cmd,
  input  logic [MAX_IDENTITIES-1:0] q_eq,
  input  logic [MAX_IDENTITIES-1:0] q_fin_ok,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      status
);

  logic [COUNT_W-1:0]        identity_count;
  logic [MAX_IDENTITIES-1:0] cand;
  logic                      ended;
  logic [MAX_IDENTITIES-1:0] mask;
  logic [MAX_IDENTITIES-1:0] cand0, cand1, cand_next;
  logic                      ended0, ended1, ended_next;
  logic                      out_free;

  for (genvar e = 0; e < MAX_IDENTITIES; e++) begin : g_mask
    assign mask[e] = (32'(identity_count) > e);
  end

  always_comb begin
    ended0 = q_cmd.clr_ended ? 1'b0 : ended;
    cand0 = q_cmd.start ? '1 : cand;
    cand1 = cand0;
    ended1 = ended0;
    if (q_cmd.cmp_a && !ended0) begin
      cand1 = cand0 & q_eq;
      ended1 = q_cmd.a_zero;
    end
    cand_next = cand1;
    ended_next = ended1;
    if (q_cmd.fin) begin
      if (!ended1) begin
        cand_next = cand1 & q_fin_ok;
      end
      ended_next = 1'b0;
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign q_pop = !q_empty && (!q_cmd.done || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      identity_count <= '0;
      cand <= '0;
      ended <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        identity_count <= cfg_data;
      end
      if (q_pop) begin
        cand <= cand_next;
        ended <= ended_next;
      end
      if (out_free) begin
        out_valid <= q_pop && q_cmd.done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.done) begin
      status <= (|(cand_next & mask)) ? STATUS_SUCCESS : STATUS_FAILURE;
    end
  end

  a_reply_taken: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_cmd.done) |=> out_valid)
    else $error("completed frame produced no reply");

endmodule

FILE: rtl/userpass_auth_frame_checker.sv
// ----------------------------------------------------------------------------
// userpass_auth_frame_checker
// Byte-serial username/password request checker against an identity table.
// ----------------------------------------------------------------------------
// The block takes one item per clock while input stall is low. A stream byte
// is parsed and its table reads issued in the accepting cycle, compared
// against every entry in the next cycle, and then queued; the matcher takes
// one queued byte per clock unless output stall holds a reply, and registers
// the reply. Table loads take effect for the next stream byte. Each entry
// holds its name and password in two RAMs with two read ports, one for the
// byte position and one for the position that closes a field. Input stall
// rises only when the reply output is held long enough for the compare stage
// and the four-entry queue to fill.
module userpass_auth_frame_checker
  import uafc_pkg::*;
#(
  parameter int MAX_IDENTITIES = 8,
  parameter int MAX_STRING_BYTES = 255
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic [7:0]         data_byte,
  input  logic [2:0]         entry_index,
  input  logic               which_string,
  input  logic [POS_W-1:0]   char_position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         reply_version,
  output logic               status
);

  localparam int CW = $bits(uafc_cmd_t);
  localparam int QW = CW + 2 * MAX_IDENTITIES;

  logic                      push;
  uafc_cmd_t                 f_cmd;
  logic [MAX_IDENTITIES-1:0] f_eq;
  logic [MAX_IDENTITIES-1:0] f_fin_ok;
  logic [QW-1:0]             q_rdata;
  logic                      q_pop;
  logic                      q_empty;
  logic [QCNT_W-1:0]         q_count;
  uafc_cmd_t                 q_cmd;
  logic [MAX_IDENTITIES-1:0] q_eq;
  logic [MAX_IDENTITIES-1:0] q_fin_ok;

  assign in_stall = (q_count + QCNT_W'(push)) >= QCNT_W'(QUEUE_DEPTH);

  uafc_front #(
    .MAX_IDENTITIES(MAX_IDENTITIES),
    .MAX_STRING_BYTES(MAX_STRING_BYTES)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(in_valid && !in_stall),
    .action(action),
    .data_byte(data_byte),
    .entry_index(entry_index),
    .which_string(which_string),
    .char_position(char_position),
    .push(push),
    .cmd(f_cmd),
    .eq(f_eq),
    .fin_ok(f_fin_ok)
  );

  uafc_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .wdata({f_cmd, f_eq, f_fin_ok}),
    .pop(q_pop),
    .rdata(q_rdata),
    .empty(q_empty),
    .count(q_count)
  );

  assign q_cmd = q_rdata[QW-1 -: CW];
  assign q_eq = q_rdata[2*MAX_IDENTITIES-1 -: MAX_IDENTITIES];
  assign q_fin_ok = q_rdata[MAX_IDENTITIES-1:0];

  uafc_back #(
    .MAX_IDENTITIES(MAX_IDENTITIES)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .q_empty(q_empty),
    .q_cmd(q_cmd),
    .q_eq(q_eq),
    .q_fin_ok(q_fin_ok),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status)
  );

  assign reply_version = AUTH_V1;

endmodule
